>>> sv/gcd_pkg.sv
// gcd_pkg: shared types and constants for the greatest common divisor block
// operand width, beat structs, datapath op codes, fsm states and control structs
// no dependencies
package gcd_pkg;

  localparam int unsigned OperandBits = 63;
  localparam int unsigned CountBits   = $clog2(OperandBits + 1);

  typedef struct packed {
    logic [OperandBits-1:0] first_value;
    logic [OperandBits-1:0] second_value;
  } gcd_in_t;

  typedef struct packed {
    logic [OperandBits-1:0] divisor;
    logic                   both_zero;
  } gcd_out_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SWAP,
    OP_SHIFT_BOTH,
    OP_SHIFT_B,
    OP_SUB,
    OP_SHIFT_UP
  } gcd_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_RUN,
    S_SCALE,
    S_DONE
  } gcd_state_e;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_odd;
    logic b_odd;
    logic a_gt_b;
    logic k_zero;
    logic out_free;
  } gcd_status_t;

  typedef struct packed {
    gcd_op_e op;
    logic    in_ready;
    logic    result_load;
  } gcd_ctrl_t;

endpackage

>>> sv/greatest_common_divisor.sv
// greatest_common_divisor: top level of the iterative binary gcd block
// depends on gcd_pkg, gcd_datapath and gcd_ctrl
//
// Computes gcd(first_value, second_value) of two unsigned operands of
// gcd_pkg::OperandBits bits and returns one result beat per input beat.
// gcd(x,0) and gcd(0,x) give x; gcd(0,0) gives 0 with both_zero set.
// The work runs on one shared subtract/compare unit and one-bit shifters
// under a small sequencer (binary gcd): it loads the operands, strips
// common factors of two, runs the main loop of halving, swap and subtract
// steps, and then restores the factors of two.
// The time an item takes depends on its operands, mostly on the number of
// subtract/swap/halve steps in the main loop.
// in_ready_o is high only while the sequencer is idle. The result sits in
// an output register, so a new beat is taken while an older result waits.
module greatest_common_divisor import gcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gcd_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gcd_out_t out_o
);

  gcd_status_t status, dp_status;
  gcd_ctrl_t   ctrl;
  gcd_out_t    result;
  gcd_out_t    out_q;
  logic        out_valid_q, out_valid_d;

  // operand registers and shared arithmetic
  gcd_datapath u_datapath (
    .clk_i    (clk_i),
    .in_i     (in_i),
    .op_i     (ctrl.op),
    .status_o (dp_status),
    .result_o (result)
  );

  // output slot is free when empty or being drained this cycle
  always_comb begin
    status          = dp_status;
    status.out_free = !out_valid_q || out_ready_i;
  end

  // sequencer
  gcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = ctrl.in_ready;

  // output register, decouples the result from the next computation
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.result_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.result_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  // a zero-pair result always carries a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.both_zero |-> out_o.divisor == '0)
    else $error("both_zero result with nonzero divisor");

  // sequencer goes busy right after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  // a result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.result_load |-> !out_valid_q || out_ready_i)
    else $error("result loaded into a full output register");
`endif

endmodule

>>> sv/gcd_datapath.sv
// gcd_datapath: operand registers, shift count and the one shared subtractor
// depends on gcd_pkg
module gcd_datapath import gcd_pkg::*; (
  input  logic        clk_i,
  input  gcd_in_t     in_i,
  input  gcd_op_e     op_i,
  output gcd_status_t status_o,
  output gcd_out_t    result_o
);

  logic [OperandBits-1:0] a_q, a_d, b_q, b_d;
  logic [CountBits-1:0]   k_q, k_d;
  logic                   zero_q, zero_d;
  logic [OperandBits:0]   diff;

  // shared compare and subtract: borrow means a > b
  assign diff = {1'b0, b_q} - {1'b0, a_q};

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    zero_d = zero_q;
    case (op_i)
      OP_LOAD: begin
        a_d    = in_i.first_value;
        b_d    = in_i.second_value;
        k_d    = '0;
        zero_d = (in_i.first_value == '0) && (in_i.second_value == '0);
      end
      OP_SWAP: begin
        a_d = b_q;
        b_d = a_q;
      end
      OP_SHIFT_BOTH: begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + CountBits'(1);
      end
      OP_SHIFT_B: b_d = b_q >> 1;
      OP_SUB:     b_d = diff[OperandBits-1:0];
      OP_SHIFT_UP: begin
        a_d = a_q << 1;
        k_d = k_q - CountBits'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    k_q    <= k_d;
    zero_q <= zero_d;
  end

  assign status_o.a_zero   = (a_q == '0);
  assign status_o.b_zero   = (b_q == '0);
  assign status_o.a_odd    = a_q[0];
  assign status_o.b_odd    = b_q[0];
  assign status_o.a_gt_b   = diff[OperandBits];
  assign status_o.k_zero   = (k_q == '0);
  assign status_o.out_free = 1'b0;

  assign result_o.divisor   = a_q;
  assign result_o.both_zero = zero_q;

endmodule

>>> sv/gcd_ctrl.sv
// gcd_ctrl: sequencer that steps the binary gcd through the shared datapath
// depends on gcd_pkg
module gcd_ctrl import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  gcd_status_t status_i,
  output gcd_ctrl_t   ctrl_o
);

  gcd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    ctrl_o.op          = OP_HOLD;
    ctrl_o.in_ready    = 1'b0;
    ctrl_o.result_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          state_d   = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (status_i.a_zero) begin
          ctrl_o.op = OP_SWAP;
          state_d   = S_DONE;
        end else if (status_i.b_zero) begin
          state_d = S_DONE;
        end else if (!status_i.a_odd && !status_i.b_odd) begin
          ctrl_o.op = OP_SHIFT_BOTH;
        end else if (!status_i.a_odd) begin
          ctrl_o.op = OP_SWAP;
          state_d   = S_RUN;
        end else begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        // a stays odd here
        if (status_i.b_zero) begin
          state_d = S_SCALE;
        end else if (!status_i.b_odd) begin
          ctrl_o.op = OP_SHIFT_B;
        end else if (status_i.a_gt_b) begin
          ctrl_o.op = OP_SWAP;
        end else begin
          ctrl_o.op = OP_SUB;
        end
      end
      S_SCALE: begin
        if (status_i.k_zero) begin
          state_d = S_DONE;
        end else begin
          ctrl_o.op = OP_SHIFT_UP;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          ctrl_o.result_load = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> dv/greatest_common_divisor_tb.sv
// greatest_common_divisor_tb: self-checking bench for the gcd block, directed table then random
// operand pairs, every result beat checked in order against a typed result or euclid predictor
// depends on gcd_pkg and greatest_common_divisor
module greatest_common_divisor_tb;
  import gcd_pkg::*;

  // run bounds, with room for the slowest items plus stalls and gaps
  localparam int unsigned NumDirected  = 23;
  localparam int unsigned NumRandom    = 1530;
  localparam int unsigned SteadyStart  = 700;
  localparam int unsigned SteadyStop   = 1000;
  localparam int unsigned DrainCycles  = 4 * OperandBits + 32;
  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned IdlePercent  = 26;
  localparam int unsigned FibLast      = 92;

  localparam logic [OperandBits-1:0] OperandMax = '1;
  localparam logic [OperandBits-1:0] OperandOne = 1;

  // one row of the directed table: operands plus an optional hand-typed result
  typedef struct packed {
    gcd_in_t  operands;
    logic     known;
    gcd_out_t known_result;
  } directed_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  gcd_in_t  in_i        = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  gcd_out_t out_o;

  gcd_out_t               expected_gcds [$];
  directed_row_t          directed_rows [NumDirected];
  logic [OperandBits-1:0] fib_seq [0:FibLast];
  int unsigned            beats_sent     = 0;
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count    = 0;
  bit                     steady         = 1'b0;

  greatest_common_divisor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // 10 unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // euclid by remainders, the flag raised only for the all-zero pair
  function automatic gcd_out_t predict_gcd(gcd_in_t pair);
    logic [OperandBits-1:0] big;
    logic [OperandBits-1:0] little;
    logic [OperandBits-1:0] rem;
    gcd_out_t               res;
    big    = (pair.first_value > pair.second_value) ? pair.first_value : pair.second_value;
    little = (pair.first_value > pair.second_value) ? pair.second_value : pair.first_value;
    while (little != 0) begin
      rem    = big % little;
      big    = little;
      little = rem;
    end
    res.divisor   = big;
    res.both_zero = (pair.first_value == 0) && (pair.second_value == 0);
    return res;
  endfunction

  // random value of at most nbits bits
  function automatic logic [OperandBits-1:0] rand_bits(int unsigned nbits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (nbits >= OperandBits) return raw[OperandBits-1:0];
    return raw[OperandBits-1:0] & ((OperandOne << nbits) - OperandOne);
  endfunction

  // idle roughly a quarter of the time, except inside the steady window
  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IdlePercent);
  endfunction

  task automatic put_row(input int unsigned idx, input logic [OperandBits-1:0] a,
                         input logic [OperandBits-1:0] b, input logic known,
                         input logic [OperandBits-1:0] div, input logic zero);
    directed_rows[idx].operands.first_value  = a;
    directed_rows[idx].operands.second_value = b;
    directed_rows[idx].known                 = known;
    directed_rows[idx].known_result.divisor  = div;
    directed_rows[idx].known_result.both_zero = zero;
  endtask

  // drive one input beat, hold it until taken, then queue its expected result;
  // ready is looked at on the falling edge, where everything is settled
  task automatic send_beat(input gcd_in_t pair, input gcd_out_t want);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= pair;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_gcds = {expected_gcds, want};
    beats_sent++;
    steady = (beats_sent >= SteadyStart) && (beats_sent < SteadyStop);
  endtask

  // receiver backpressure, one update per rising edge
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePercent);
  end

  // result checker: a beat seen valid and ready at the falling edge is taken at the next rise
  always @(negedge clk_i) begin
    gcd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_gcds.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual divisor %0d flag %0b",
                 $time, out_o.divisor, out_o.both_zero);
        mismatch_count++;
      end else begin
        want = expected_gcds.pop_front();
        if (out_o.divisor !== want.divisor) begin
          $display("%0t: divisor mismatch, expected %0d, actual %0d",
                   $time, want.divisor, out_o.divisor);
          mismatch_count++;
        end
        if (out_o.both_zero !== want.both_zero) begin
          $display("%0t: both_zero mismatch, expected %0b, actual %0b",
                   $time, want.both_zero, out_o.both_zero);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    gcd_in_t                pair;
    gcd_out_t               want;
    logic [OperandBits-1:0] tmp;
    logic [OperandBits-1:0] fac;
    int unsigned            nbits;
    int unsigned            idx;
    int unsigned            shape;

    // fibonacci pairs are the longest remainder chains
    fib_seq[0] = 0;
    fib_seq[1] = 1;
    for (int i = 2; i <= FibLast; i++) fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];

    // directed table; known rows carry a result that can be read off directly
    put_row(0,  '0, '0, 1'b1, '0, 1'b1);                       // both operands zero
    put_row(1,  '0, OperandMax, 1'b1, OperandMax, 1'b0);       // zero first
    put_row(2,  OperandMax, '0, 1'b1, OperandMax, 1'b0);       // zero second
    put_row(3,  63'd12345, '0, 1'b1, 63'd12345, 1'b0);
    put_row(4,  '0, OperandOne, 1'b1, OperandOne, 1'b0);
    put_row(5,  OperandOne, OperandOne, 1'b1, OperandOne, 1'b0);
    put_row(6,  OperandMax, OperandMax, 1'b1, OperandMax, 1'b0);
    put_row(7,  OperandMax, OperandOne, 1'b1, OperandOne, 1'b0);
    put_row(8,  OperandOne, OperandMax, 1'b1, OperandOne, 1'b0);
    put_row(9,  OperandMax, OperandMax - 1, 1'b1, OperandOne, 1'b0);
    put_row(10, OperandOne << 62, OperandOne << 62, 1'b1, OperandOne << 62, 1'b0);
    put_row(11, OperandOne << 62, OperandOne << 61, 1'b1, OperandOne << 61, 1'b0);
    put_row(12, OperandOne << 62, 63'd3, 1'b1, OperandOne, 1'b0);
    put_row(13, 63'd48, 63'd18, 1'b1, 63'd6, 1'b0);
    put_row(14, 63'd18, 63'd48, 1'b1, 63'd6, 1'b0);
    put_row(15, 63'd2, OperandOne << 62, 1'b1, 63'd2, 1'b0);
    put_row(16, fib_seq[FibLast], fib_seq[FibLast-1], 1'b0, '0, 1'b0);
    put_row(17, fib_seq[FibLast-1], fib_seq[FibLast], 1'b0, '0, 1'b0);
    put_row(18, OperandMax, 63'd7, 1'b0, '0, 1'b0);
    put_row(19, 63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa, 1'b0, '0, 1'b0);
    put_row(20, (OperandOne << 62) | OperandOne, OperandOne << 61, 1'b0, '0, 1'b0);
    put_row(21, 63'd9223372036854775783, 63'd9223372036854775643, 1'b0, '0, 1'b0);
    put_row(22, 63'd600851475143, 63'd6857, 1'b0, '0, 1'b0);

    // hold reset, then release it
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      want = directed_rows[r].known ? directed_rows[r].known_result
                                    : predict_gcd(directed_rows[r].operands);
      send_beat(directed_rows[r].operands, want);
    end

    // random part: a mix of operand shapes aimed at different loop behavior
    for (int n = 0; n < NumRandom; n++) begin
      shape = $urandom_range(0, 99);
      if (shape < 25) begin
        // wide random, magnitudes far apart now and then
        pair.first_value  = rand_bits(OperandBits);
        pair.second_value = rand_bits($urandom_range(1, OperandBits));
      end else if (shape < 45) begin
        // shared factor so the result is large
        nbits = $urandom_range(1, 31);
        fac   = rand_bits(nbits);
        if (fac == 0) fac = OperandOne;
        pair.first_value  = fac * rand_bits(62 - nbits);
        pair.second_value = fac * rand_bits(62 - nbits);
      end else if (shape < 60) begin
        // common powers of two to strip and restore
        nbits = $urandom_range(1, OperandBits - 1);
        pair.first_value  = rand_bits(OperandBits - nbits) << nbits;
        pair.second_value = rand_bits(OperandBits - nbits) << nbits;
      end else if (shape < 70) begin
        pair.first_value  = rand_bits(8);
        pair.second_value = rand_bits(8);
      end else if (shape < 78) begin
        // one or both operands zero
        tmp = rand_bits($urandom_range(1, OperandBits));
        case ($urandom_range(0, 4))
          0:       pair = '0;
          1, 2:    begin pair.first_value = '0; pair.second_value = tmp; end
          default: begin pair.first_value = tmp; pair.second_value = '0; end
        endcase
      end else if (shape < 86) begin
        tmp = rand_bits($urandom_range(1, OperandBits));
        pair.first_value  = tmp;
        pair.second_value = tmp;
      end else if (shape < 94) begin
        // consecutive fibonacci numbers: coprime, longest chain for their size
        idx = $urandom_range(1, FibLast - 1);
        pair.first_value  = fib_seq[idx+1];
        pair.second_value = fib_seq[idx];
      end else begin
        // near the top of the range, single bits
        case ($urandom_range(0, 3))
          0: begin pair.first_value = OperandMax; pair.second_value = rand_bits(OperandBits); end
          1: begin
            pair.first_value  = OperandOne << $urandom_range(0, OperandBits - 1);
            pair.second_value = rand_bits(OperandBits);
          end
          2: begin
            pair.first_value  = OperandMax - rand_bits(8);
            pair.second_value = OperandMax - rand_bits(8);
          end
          default: begin
            pair.first_value  = OperandOne << $urandom_range(0, OperandBits - 1);
            pair.second_value = OperandOne << $urandom_range(0, OperandBits - 1);
          end
        endcase
      end
      // random operand order
      if ($urandom_range(0, 1)) begin
        tmp               = pair.first_value;
        pair.first_value  = pair.second_value;
        pair.second_value = tmp;
      end
      send_beat(pair, predict_gcd(pair));
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;

    // drain, then linger to catch stray result beats
    while (expected_gcds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
